// ===== rtl/core/fcmef_pkg.sv =====
// ----------------------------------------------------------------------------
// fcmef_pkg
// Shared types and constants of the five-lane median and moving-average filter.
// ----------------------------------------------------------------------------
package fcmef_pkg;

  localparam int NumLanes = 5;

  typedef enum logic [2:0] {
    REG_ALPHA_TEMP  = 3'd0,
    REG_ALPHA_HUMID = 3'd1,
    REG_ALPHA_PRESS = 3'd2,
    REG_ALPHA_LIGHT = 3'd3,
    REG_ALPHA_GAS   = 3'd4,
    REG_MEDIAN_MASK = 3'd5
  } reg_idx_e;

  localparam logic [NumLanes-1:0] MedianMaskReset = 5'd24;

  typedef struct packed {
    logic load;
    logic advance;
    logic primed;
    logic first;
  } lane_ctl_t;

endpackage

// ===== rtl/core/five_channel_median_ema_filter.sv =====
// ----------------------------------------------------------------------------
// five_channel_median_ema_filter
// Five sensor lanes, each with optional median of three and an EMA, working
// side by side; the output stage gathers the lanes into one result beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                     | payload
//  in      | input     | in_valid_i / in_ready_o       | five signed samples
//  out     | output    | out_valid_o / out_ready_i     | five signed EMA values
//  cfg     | input     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One beat per cycle is sustained while the output is not stalled; a beat's result
// passes through the median register stage and then the EMA update stage.
// The EMA registers are the output register, so a stalled output holds them
// while one more input beat waits in the median stage.
// Reset clears the EMA values and the primed flag; the first beat after reset
// fills every window and primes every lane.
// ----------------------------------------------------------------------------
module five_channel_median_ema_filter import fcmef_pkg::*; #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] temperature_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] humidity_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] pressure_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] light_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gas_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] temperature_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] humidity_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] pressure_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] light_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] gas_out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [NumLanes-1:0][ALPHA_FRAC_BITS:0] alpha;
  logic [NumLanes-1:0]                    mask;
  logic signed [SAMPLE_WIDTH-1:0]         samp [NumLanes];
  logic signed [SAMPLE_WIDTH-1:0]         ema  [NumLanes];

  logic      a_valid_q, a_valid_d;
  logic      a_first_q;
  logic      out_valid_q, out_valid_d;
  logic      primed_q;
  logic      in_fire, adv;
  lane_ctl_t ctl;

  fcmef_cfg #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .alpha_o (alpha),
    .mask_o  (mask)
  );

  assign adv        = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    a_valid_d   = in_fire || (a_valid_q && !adv);
    out_valid_d = adv || (out_valid_q && !out_ready_i);
    ctl.load    = in_fire;
    ctl.advance = adv;
    ctl.primed  = primed_q;
    ctl.first   = a_first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
      a_first_q   <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        primed_q  <= 1'b1;
        a_first_q <= !primed_q;
      end
    end
  end

  assign samp[0] = temperature_in_i;
  assign samp[1] = humidity_in_i;
  assign samp[2] = pressure_in_i;
  assign samp[3] = light_in_i;
  assign samp[4] = gas_in_i;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    fcmef_lane #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .sample_i    (samp[i]),
      .alpha_i     (alpha[i]),
      .median_en_i (mask[i]),
      .ema_o       (ema[i])
    );
  end

  assign out_valid_o       = out_valid_q;
  assign temperature_out_o = ema[0];
  assign humidity_out_o    = ema[1];
  assign pressure_out_o    = ema[2];
  assign light_out_o       = ema[3];
  assign gas_out_o         = ema[4];

endmodule

// ===== rtl/core/fcmef_cfg.sv =====
// ----------------------------------------------------------------------------
// fcmef_cfg
// Register file behind the APB-style port: per-lane alpha and the median mask.
// ----------------------------------------------------------------------------
module fcmef_cfg import fcmef_pkg::*; #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [4:0]                                 paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready,
  output logic [NumLanes-1:0][ALPHA_FRAC_BITS:0]     alpha_o,
  output logic [NumLanes-1:0]                        mask_o
);

  localparam int AlphaWidth = ALPHA_FRAC_BITS + 1;
  localparam int One        = 1 << ALPHA_FRAC_BITS;
  localparam logic [AlphaWidth-1:0] Alpha20 = AlphaWidth'((2 * One + 5) / 10);
  localparam logic [AlphaWidth-1:0] Alpha15 = AlphaWidth'((15 * One + 50) / 100);
  localparam logic [AlphaWidth-1:0] Alpha30 = AlphaWidth'((3 * One + 5) / 10);
  localparam logic [NumLanes-1:0][AlphaWidth-1:0] AlphaReset =
    {Alpha30, Alpha30, Alpha15, Alpha20, Alpha20};

  logic [NumLanes-1:0][AlphaWidth-1:0] alpha_q;
  logic [NumLanes-1:0]                 mask_q;
  reg_idx_e                            idx;
  logic                                wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
      mask_q  <= MedianMaskReset;
    end else if (wr_en) begin
      if (idx inside {[REG_ALPHA_TEMP:REG_ALPHA_GAS]}) begin
        alpha_q[idx] <= pwdata[AlphaWidth-1:0];
      end else if (idx == REG_MEDIAN_MASK) begin
        mask_q <= pwdata[NumLanes-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx inside {[REG_ALPHA_TEMP:REG_ALPHA_GAS]}) begin
      prdata = 32'(alpha_q[idx]);
    end else if (idx == REG_MEDIAN_MASK) begin
      prdata = 32'(mask_q);
    end
  end

  assign alpha_o = alpha_q;
  assign mask_o  = mask_q;

endmodule

// ===== rtl/core/fcmef_lane.sv =====
// ----------------------------------------------------------------------------
// fcmef_lane
// One filter lane: two-sample window, median of three, then the EMA update.
// ----------------------------------------------------------------------------
module fcmef_lane import fcmef_pkg::*; #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lane_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [ALPHA_FRAC_BITS:0]       alpha_i,
  input  logic                           median_en_i,
  output logic signed [SAMPLE_WIDTH-1:0] ema_o
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int AW = ALPHA_FRAC_BITS + 1;
  localparam logic [AW-1:0] AlphaOne = AW'(1) << ALPHA_FRAC_BITS;

  logic signed [W-1:0]      s0_q, s1_q, v_q, ema_q;
  logic signed [W-1:0]      s0_d, s1_d, v_d, ema_d;
  logic signed [W-1:0]      lo, hi, mid, med;
  logic [AW-1:0]            alpha_sat;
  logic signed [W:0]        diff, step, sum;
  logic signed [W+AW+1:0]   prod, prod_sh;

  always_comb begin
    lo  = (s0_q < s1_q) ? s0_q : s1_q;
    hi  = (s0_q < s1_q) ? s1_q : s0_q;
    mid = (hi < sample_i) ? hi : sample_i;
    med = (lo > mid) ? lo : mid;
    v_d = (median_en_i && ctl_i.primed) ? med : sample_i;
    s0_d = ctl_i.primed ? s1_q : sample_i;
    s1_d = sample_i;
  end

  always_comb begin
    alpha_sat = (alpha_i > AlphaOne) ? AlphaOne : alpha_i;
    diff      = {v_q[W-1], v_q} - {ema_q[W-1], ema_q};
    prod      = (W+AW+2)'(diff) * $signed({1'b0, alpha_sat});
    prod_sh   = prod >>> ALPHA_FRAC_BITS;
    step      = prod_sh[W:0];
    sum       = {ema_q[W-1], ema_q} + step;
    ema_d     = ctl_i.first ? v_q : sum[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      v_q  <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q <= '0;
    end else if (ctl_i.advance) begin
      ema_q <= ema_d;
    end
  end

  assign ema_o = ema_q;

endmodule

// ===== rtl/core/fcmef_checker.sv =====
// ----------------------------------------------------------------------------
// fcmef_checker
// Port-level checks of the filter's flow control and register file.
// ----------------------------------------------------------------------------
module fcmef_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] temperature_out_o,
  input logic signed [SAMPLE_WIDTH-1:0] humidity_out_o,
  input logic signed [SAMPLE_WIDTH-1:0] pressure_out_o,
  input logic signed [SAMPLE_WIDTH-1:0] light_out_o,
  input logic signed [SAMPLE_WIDTH-1:0] gas_out_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [4:0]                     paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);

  localparam logic [4:0] MaskAddr = 5'd20;

  // Input back-pressure only ever comes from a stalled output beat.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // A valid output beat follows each accepted beat.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 out_valid_o)
    else $error("accepted beat did not reach the output");

  // A stalled output beat holds its values.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(temperature_out_o)
      && $stable(humidity_out_o) && $stable(pressure_out_o)
      && $stable(light_out_o) && $stable(gas_out_o)))
    else $error("stalled output beat changed");

  // The median mask reads back what was last written.
  a_mask_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == MaskAddr)
      ##1 (psel && !pwrite && paddr == MaskAddr)
      |-> prdata == {27'd0, $past(pwdata[4:0])})
    else $error("median mask read-back mismatch");

endmodule

bind five_channel_median_ema_filter fcmef_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fcmef_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the five-lane median and moving-average filter.
// A directed stimulus table covers priming, sample extremes, alpha zero, one
// and above one, median selection and writes to unused register slots. Random
// beats under changing register settings and handshake idling follow. A
// predictor in the bench computes the expected beats the table leaves open, and
// each output beat is compared lane by lane in order.
// ----------------------------------------------------------------------------
module tb;
  import fcmef_pkg::*;

  localparam int          SampleW       = 32;
  localparam int          AlphaFrac     = 16;
  localparam logic [16:0] AlphaUnity    = 17'h10000;
  localparam logic [16:0] AlphaTop      = 17'h1FFFF;
  localparam logic [31:0] AlphaField    = 32'h0001_FFFF;
  localparam logic [31:0] MaskField     = 32'h0000_001F;
  localparam logic [31:0] MinSample     = 32'h8000_0000;
  localparam logic [31:0] MaxSample     = 32'h7FFF_FFFF;
  localparam logic [2:0]  RegSpareA     = 3'd6;
  localparam logic [2:0]  RegSpareB     = 3'd7;
  localparam int          NumPhases     = 10;
  localparam int          BeatsPerPhase = 125;
  localparam int          HoldCycles    = 64;
  localparam int          DrainCycles   = 16;
  localparam int          CycleLimit    = 200000;

  typedef logic [NumLanes-1:0][SampleW-1:0] lane_vec_t;
  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    lane_vec_t   smp;
    bit          known;
    lane_vec_t   want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  lane_vec_t   in_lanes;
  logic        out_valid_o;
  logic        out_ready_i;
  wire  [NumLanes-1:0][SampleW-1:0] out_lanes;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [16:0]         alpha_sh [NumLanes] = '{17'd13107, 17'd13107, 17'd9830,
                                               17'd19661, 17'd19661};
  logic [NumLanes-1:0] mask_sh = MedianMaskReset;
  longint              ema_st  [NumLanes];
  longint              win_old [NumLanes];
  longint              win_new [NumLanes];
  bit                  primed_st = 1'b0;

  lane_vec_t   pending_ema_q [$];
  stim_row_t   plan_q [$];
  string       lane_name [NumLanes] = '{"temperature", "humidity", "pressure", "light",
                                        "gas"};
  int unsigned tx_idle_pct = 29;
  int unsigned rx_idle_pct = 47;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  five_channel_median_ema_filter u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .temperature_in_i (in_lanes[0]),
    .humidity_in_i    (in_lanes[1]),
    .pressure_in_i    (in_lanes[2]),
    .light_in_i       (in_lanes[3]),
    .gas_in_i         (in_lanes[4]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .temperature_out_o(out_lanes[0]),
    .humidity_out_o   (out_lanes[1]),
    .pressure_out_o   (out_lanes[2]),
    .light_out_o      (out_lanes[3]),
    .gas_out_o        (out_lanes[4]),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic lane_vec_t lanes(input logic [31:0] t, h, p, l, g);
    return {g, l, p, h, t};
  endfunction

  function automatic void plan_beat(input lane_vec_t smp, input bit known,
                                    input lane_vec_t want);
    stim_row_t row;
    row.kind  = ROW_BEAT;
    row.idx   = REG_ALPHA_TEMP;
    row.data  = '0;
    row.smp   = smp;
    row.known = known;
    row.want  = want;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_write(input logic [2:0] idx, input logic [31:0] data);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.data  = data;
    row.smp   = '0;
    row.known = 1'b0;
    row.want  = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_all_alpha(input logic [16:0] a);
    for (int k = 0; k < NumLanes; k++) begin
      plan_write(reg_idx_e'(k), 32'(a));
    end
  endfunction

  function automatic lane_vec_t advance_filter(input lane_vec_t smp);
    lane_vec_t res;
    longint    x;
    longint    v;
    longint    a;
    longint    b;
    longint    gain;
    for (int k = 0; k < NumLanes; k++) begin
      x = longint'($signed(smp[k]));
      if (!primed_st) begin
        win_old[k] = x;
        win_new[k] = x;
        ema_st[k]  = x;
      end else begin
        a = win_old[k];
        b = win_new[k];
        v = x;
        if (mask_sh[k]) begin
          v = (a > b) ? ((b > x) ? b : ((a > x) ? x : a))
                      : ((a > x) ? a : ((b > x) ? x : b));
        end
        win_old[k] = b;
        win_new[k] = x;
        gain = (alpha_sh[k] > AlphaUnity) ? longint'(AlphaUnity) : longint'(alpha_sh[k]);
        ema_st[k] = ema_st[k] + ((gain * (v - ema_st[k])) >>> AlphaFrac);
      end
      res[k] = ema_st[k][SampleW-1:0];
    end
    primed_st = 1'b1;
    return res;
  endfunction

  task automatic send_beat(input lane_vec_t smp, input bit known, input lane_vec_t want);
    lane_vec_t ema;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_lanes   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    ema = advance_filter(smp);
    pending_ema_q.push_back(known ? want : ema);
  endtask

  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_ema_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = (idx < NumLanes) ? 32'(alpha_sh[idx]) : 32'(mask_sh);
    if (wr) begin
      if (idx < NumLanes) begin
        alpha_sh[idx] = data[16:0];
      end else if (idx == REG_MEDIAN_MASK) begin
        mask_sh = data[NumLanes-1:0];
      end
    end else if (idx <= REG_MEDIAN_MASK && prdata !== want) begin
      $display("%0t: register %0d read expected %h got %h", $time, idx, want, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result beats are checked against the oldest expectation, then the
  // receiver decides its ready for the next cycle.
  always @(posedge clk_i) begin
    lane_vec_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_ema_q.size() == 0) begin
        $display("%0t: result beat with no expectation: %h", $time, out_lanes);
        err_cnt++;
      end else begin
        want = pending_ema_q.pop_front();
        for (int k = 0; k < NumLanes; k++) begin
          if (out_lanes[k] !== want[k]) begin
            $display("%0t: %s expected %0d got %0d", $time, lane_name[k],
                     $signed(want[k]), $signed(out_lanes[k]));
            err_cnt++;
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    lane_vec_t   p_set;
    lane_vec_t   r_set;
    lane_vec_t   spike;
    lane_vec_t   smp;
    logic [31:0] base [NumLanes];
    logic [16:0] a;
    logic [4:0]  m;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_lanes    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;

    p_set = lanes(32'h0000_1900, 32'h0000_3C80, 32'h018B_A300, 32'h0001_F400, 32'hFFFF_FF00);
    r_set = lanes(32'hFFFF_F600, 32'h0000_0100, 32'h0100_0000, 32'h0000_0000, 32'h0012_3456);
    spike = lanes(MaxSample, MinSample, MaxSample, MinSample, MaxSample);

    plan_beat(lanes(MinSample, MaxSample, '0, '1, 32'd1), 1'b1,
              lanes(MinSample, MaxSample, '0, '1, 32'd1));
    plan_beat(lanes(MaxSample, MinSample, '1, '0, MaxSample), 1'b0, '0);
    plan_beat(lanes(MinSample, MinSample, MaxSample, MaxSample, MinSample), 1'b0, '0);
    plan_beat(lanes('0, '0, '0, 32'h0010_0000, 32'hFFF0_0000), 1'b0, '0);
    plan_beat(lanes('0, '0, '0, '0, '0), 1'b0, '0);
    plan_all_alpha(AlphaUnity);
    plan_write(REG_MEDIAN_MASK, 32'h0000_0000);
    plan_beat(r_set, 1'b1, r_set);
    plan_all_alpha(AlphaTop);
    plan_beat(p_set, 1'b1, p_set);
    plan_beat(p_set, 1'b1, p_set);
    plan_write(REG_MEDIAN_MASK, MaskField);
    plan_beat(spike, 1'b1, p_set);
    plan_all_alpha(17'd0);
    plan_beat(lanes(MinSample, MinSample, MinSample, MinSample, MinSample), 1'b1, p_set);
    plan_write(RegSpareA, 32'hFFFF_FFFF);
    plan_write(RegSpareB, 32'hFFFF_FFFF);
    plan_beat(lanes(MaxSample, MaxSample, MaxSample, MaxSample, MaxSample), 1'b1, p_set);
    plan_all_alpha(17'd1);
    plan_write(REG_MEDIAN_MASK, 32'h0000_0000);
    plan_beat(lanes(MinSample, MinSample, MinSample, MinSample, MinSample), 1'b0, '0);
    plan_beat(lanes(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'd2, '0), 1'b0, '0);
    plan_all_alpha(17'hFFFF);
    plan_write(REG_MEDIAN_MASK, 32'h0000_0015);
    plan_beat(lanes(MaxSample, MinSample, MaxSample, MinSample, MaxSample), 1'b0, '0);
    plan_beat(lanes(MinSample, MaxSample, MinSample, MaxSample, MinSample), 1'b0, '0);
    plan_beat(lanes(32'hFFFF_FFFF, '0, 32'd1, 32'hFFFF_FF00, 32'h0000_0100), 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[r]) begin
      if (plan_q[r].kind == ROW_WRITE) begin
        drain();
        apb_access(1'b1, plan_q[r].idx, plan_q[r].data);
      end else begin
        send_beat(plan_q[r].smp, plan_q[r].known, plan_q[r].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      for (int k = 0; k < NumLanes; k++) begin
        case ($urandom_range(0, 9))
          0:       a = 17'd0;
          1:       a = AlphaUnity;
          2:       a = 17'($urandom_range(32'(AlphaUnity) + 1, 32'(AlphaTop)));
          3:       a = 17'd1;
          default: a = 17'($urandom_range(1, 32'(AlphaUnity)));
        endcase
        apb_access(1'b1, reg_idx_e'(k), ($urandom() & ~AlphaField) | 32'(a));
        base[k] = $urandom();
      end
      m = (ph == 1) ? 5'h1F : (ph == 2) ? 5'h00 : 5'($urandom_range(0, 31));
      apb_access(1'b1, REG_MEDIAN_MASK, ($urandom() & ~MaskField) | 32'(m));
      for (int k = 0; k <= REG_MEDIAN_MASK; k++) begin
        apb_access(1'b0, reg_idx_e'(k), '0);
      end
      if (ph < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 47;
      end else if (ph < 7) begin
        tx_idle_pct = 47;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == NumPhases - 1) hold_req = 1'b1;
      repeat (BeatsPerPhase) begin
        for (int k = 0; k < NumLanes; k++) begin
          case ($urandom_range(0, 9))
            0:       smp[k] = MaxSample;
            1:       smp[k] = MinSample;
            2, 3:    smp[k] = $urandom();
            default: smp[k] = base[k] + $urandom_range(0, 4095) - 2048;
          endcase
        end
        send_beat(smp, 1'b0, '0);
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
